// ===== sv/rcle_pkg.sv =====
// ----------------------------------------------------------------------------
// rcle_pkg
// Shared constants, types and the code conversion for the reply code line
// extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package rcle_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 11;
  localparam int unsigned ValW  = 10;
  localparam int unsigned NumSlots = 3;

  localparam logic [ByteW-1:0] CrByte    = 8'h0D;
  localparam logic [ByteW-1:0] LfByte    = 8'h0A;
  localparam logic [ByteW-1:0] SpaceByte = 8'h20;
  localparam logic [ByteW-1:0] TabByte   = 8'h09;
  localparam logic [ByteW-1:0] PlusByte  = 8'h2B;
  localparam logic [ByteW-1:0] MinusByte = 8'h2D;
  localparam logic [ByteW-1:0] ZeroByte  = 8'h30;
  localparam logic [ByteW-1:0] NineByte  = 8'h39;

  typedef logic [NumSlots-1:0][ByteW-1:0] slots_t;

  typedef struct packed {
    logic                    valid;
    logic signed [CodeW-1:0] code;
  } result_t;

  function automatic logic is_space(input logic [ByteW-1:0] c);
    return (c == SpaceByte) || ((c >= TabByte) && (c <= CrByte));
  endfunction

  function automatic logic is_digit(input logic [ByteW-1:0] c);
    return (c >= ZeroByte) && (c <= NineByte);
  endfunction

  // Converts the lead slots the way atoi does, limited to three characters.
  function automatic logic signed [CodeW-1:0] convert_slots(input slots_t s);
    logic            neg;
    logic            in_digits;
    logic            stopped;
    logic [ValW-1:0] val;
    logic [ValW-1:0] dig;
    neg       = 1'b0;
    in_digits = 1'b0;
    stopped   = 1'b0;
    val       = '0;
    for (int k = 0; k < NumSlots; k++) begin
      dig = ValW'(s[k] - ZeroByte);
      if (!stopped) begin
        if (!in_digits) begin
          if (is_space(s[k])) begin
            stopped = 1'b0;
          end else if ((s[k] == PlusByte) || (s[k] == MinusByte)) begin
            neg       = (s[k] == MinusByte);
            in_digits = 1'b1;
          end else if (is_digit(s[k])) begin
            val       = dig;
            in_digits = 1'b1;
          end else begin
            stopped = 1'b1;
          end
        end else if (is_digit(s[k])) begin
          val = ValW'(val * ValW'(10) + dig);
        end else begin
          stopped = 1'b1;
        end
      end
    end
    return neg ? -$signed({1'b0, val}) : $signed({1'b0, val});
  endfunction

endpackage

`default_nettype wire

// ===== sv/rcle_core.sv =====
// ----------------------------------------------------------------------------
// rcle_core
// Line state of the extractor: keeps the lead slots, line position, CR flag
// and halt flag, and forms the result of one registered byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rcle_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [rcle_pkg::ByteW-1:0]  data_byte_i,
  input  wire logic                        start_i,
  output rcle_pkg::result_t                result_o,
  output logic                             halted_o
);
  import rcle_pkg::*;

  slots_t     slots_q, slots_d;
  logic [1:0] pos_q, pos_d;
  logic       cr_q, cr_d;
  logic       halted_q, halted_d;

  logic signed [CodeW-1:0] code;
  slots_t                  slots_w;

  always_comb begin
    slots_d  = slots_q;
    pos_d    = pos_q;
    cr_d     = cr_q;
    halted_d = halted_q;
    result_o = '{valid: 1'b0, code: '0};
    slots_w  = slots_q;
    code     = '0;
    if (start_i) begin
      slots_d  = '0;
      pos_d    = '0;
      cr_d     = 1'b0;
      halted_d = 1'b0;
      result_o = '{valid: 1'b1, code: '0};
    end
    if (!halted_d) begin
      for (int k = 0; k < NumSlots; k++) begin
        if (pos_d == 2'(k)) begin
          slots_d[k] = data_byte_i;
        end
      end
      slots_w = slots_d;
      code    = convert_slots(slots_w);
      if (cr_d && (data_byte_i == LfByte)) begin
        pos_d = '0;
        cr_d  = 1'b0;
        if (code == '0) begin
          halted_d = 1'b1;
        end else begin
          result_o = '{valid: 1'b1, code: code};
        end
      end else begin
        if (pos_d != 2'd3) begin
          pos_d = pos_d + 2'd1;
        end
        cr_d = (data_byte_i == CrByte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q  <= '0;
      pos_q    <= '0;
      cr_q     <= 1'b0;
      halted_q <= 1'b1;
    end else if (step_i) begin
      slots_q  <= slots_d;
      pos_q    <= pos_d;
      cr_q     <= cr_d;
      halted_q <= halted_d;
    end
  end

  assign halted_o = halted_q;

endmodule

`default_nettype wire

// ===== sv/reply_code_line_extractor.sv =====
// ----------------------------------------------------------------------------
// reply_code_line_extractor
// Pulls the numeric reply code out of each CR LF terminated line of a
// server reply byte stream.
// ----------------------------------------------------------------------------
// Usage: each input request carries one byte of the reply buffer and a flag
// that marks the first byte of a new buffer. A start request yields a code 0
// and arms the block. When LF follows CR within a line, the first three
// bytes of that line are converted like atoi; a nonzero value is sent as a
// signed 11-bit reply code, a zero value halts the block until the next
// start. Any request produces at most one result.
// Throughput is one request per cycle while in_ready_o is high. The input
// register takes a request at its accepting edge, and the line logic writes
// the result register from it as soon as that register is free. When the
// receiver stalls, the result register holds and the input register fills;
// in_ready_o falls only when both are full and out_ready_i is low. Reset
// clears the slots and line state and leaves the block halted, waiting for
// a start request.
// ----------------------------------------------------------------------------
`default_nettype none

module reply_code_line_extractor (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [rcle_pkg::ByteW-1:0]         data_byte_i,
  input  wire logic                               start_of_buffer_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [rcle_pkg::CodeW-1:0]       reply_code_o
);
  import rcle_pkg::*;

  logic               s1_valid_q;
  logic [ByteW-1:0]   s1_byte_q;
  logic               s1_start_q;
  logic               out_valid_q;
  logic signed [CodeW-1:0] out_code_q;
  logic               out_free;
  logic               advance;
  logic               halted;
  result_t            res;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q  <= data_byte_i;
      s1_start_q <= start_of_buffer_i;
    end
  end

  rcle_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .data_byte_i (s1_byte_q),
    .start_i     (s1_start_q),
    .result_o    (res),
    .halted_o    (halted)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && res.valid) begin
      out_code_q <= res.code;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign reply_code_o = out_code_q;

`ifndef SYNTH
  a_start_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_start_q |=> out_valid_o && (reply_code_o == '0))
    else $error("start request did not produce a zero code");

  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && halted && !s1_start_q |=> !out_valid_o)
    else $error("halted block produced a result");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reply_code_o >= -11'sd99) && (reply_code_o <= 11'sd999))
    else $error("reply code out of range");

  a_line_code_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !s1_start_q && res.valid |-> (res.code != '0))
    else $error("line produced a zero code");
`endif

endmodule

`default_nettype wire
